### hdl/assert_macros.svh
// Assertion helpers used by the checker file sll_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sll_pkg.sv
`default_nettype none

package sll_pkg;

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned CNT_W    = 4;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_DONE     = 2'd0;
  localparam status_t STATUS_FULL     = 2'd1;
  localparam status_t STATUS_NOTFOUND = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

endpackage

`default_nettype wire

### hdl/sorted_linked_list_engine_top.sv
// Sorted linked-list engine: ascending list of signed values in a node store,
// slot 0 is null, unused slots sit on a free list.
// Input channel: in_valid_i / in_stall_o with operation_i (insert or delete)
// and value_i. A word is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with status_o, slot_o and
// entry_count_o, one result word per input word, in order.
// Sequence: the sequencer walks the list one node per cycle through the
// registered read port of the node store. Insert reads the free-list head,
// walks, then links in S_COMMIT and S_COMMIT2; a delete walks, then unlinks
// and frees the node there if found. The walk visits at most SLOTS-2 nodes
// on insert, SLOTS-1 on delete; a full store or empty-list delete skips it.
// Throughput: one word at a time; in_stall_o is high from acceptance until
// the result is loaded into the output register.
// The output register frees the engine: the next word can be taken while
// a result waits. A stalled receiver holds the result word unchanged, and
// the engine then waits before loading the following result.
// Reset: empty list, every slot free in slot order, no result pending.
// No clearing pass: per-slot valid bits supply the initial free-list links.
`default_nettype none

module sorted_linked_list_engine_top #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic signed [VALUE_BITS-1:0]     value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output sll_pkg::status_t                 status_o,
  output logic [sll_pkg::SLOT_W-1:0]       slot_o,
  output logic [sll_pkg::CNT_W-1:0]        entry_count_o
);
  import sll_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FREE    = 3'd1;
  localparam logic [2:0] S_WALK    = 3'd2;
  localparam logic [2:0] S_COMMIT  = 3'd3;
  localparam logic [2:0] S_COMMIT2 = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;

  logic [2:0] state_q, state_d;
  logic op_q, op_d;
  logic signed [VALUE_BITS-1:0] v_q, v_d;
  logic [IW-1:0] cur_q, cur_d, prev_q, prev_d, next_q, next_d, nfree_q, nfree_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d, used_q, used_d;
  status_t res_status_q, res_status_d;
  logic [IW-1:0] res_slot_q, res_slot_d;

  logic out_valid_q;
  status_t out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic out_load;

  logic signed [VALUE_BITS-1:0] val_mem [SLOTS];
  logic [IW-1:0] link_mem [SLOTS];
  logic [SLOTS-1:0] lvld_q;

  logic rd_en;
  logic [IW-1:0] rd_addr;
  logic signed [VALUE_BITS-1:0] val_rd_q;
  logic [IW-1:0] link_rd_q, link_ra_q;
  logic link_hit_q;
  logic val_we, link_we;
  logic [IW-1:0] link_wa, link_wd;

  logic [IW-1:0] link_nx;
  logic go_on;

  assign link_nx = link_hit_q ? link_rd_q :
                   ((link_ra_q == LAST) ? '0 : IW'(link_ra_q + 1'b1));
  assign go_on = (op_q == OP_INSERT) ? (val_rd_q < v_q) : (val_rd_q != v_q);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    v_d          = v_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    next_d       = next_q;
    nfree_d      = nfree_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_d       = free_q;
    used_d       = used_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    val_we       = 1'b0;
    link_we      = 1'b0;
    link_wa      = '0;
    link_wd      = '0;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = operation_i;
          v_d          = value_i;
          cur_d        = head_q;
          prev_d       = '0;
          res_status_d = STATUS_DONE;
          if (operation_i == OP_DELETE) begin
            if (head_q == '0) begin
              res_status_d = STATUS_NOTFOUND;
              res_slot_d   = '0;
              state_d      = S_RESP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q;
              state_d = S_WALK;
            end
          end else if (free_q == '0) begin
            res_status_d = STATUS_FULL;
            res_slot_d   = '0;
            state_d      = S_RESP;
          end else begin
            res_slot_d = free_q;
            rd_en      = 1'b1;
            rd_addr    = free_q;
            state_d    = S_FREE;
          end
        end
      end
      S_FREE: begin
        nfree_d = link_nx;
        if (cur_q == '0) begin
          state_d = S_COMMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_q;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (go_on) begin
          prev_d = cur_q;
          cur_d  = link_nx;
          if (link_nx == '0) begin
            if (op_q == OP_INSERT) begin
              state_d = S_COMMIT;
            end else begin
              res_status_d = STATUS_NOTFOUND;
              res_slot_d   = '0;
              state_d      = S_RESP;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = link_nx;
          end
        end else begin
          next_d  = link_nx;
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (op_q == OP_INSERT) begin
          val_we  = 1'b1;
          link_we = 1'b1;
          link_wa = res_slot_q;
          link_wd = cur_q;
          if (cur_q == '0) begin
            tail_d = res_slot_q;
          end
          free_d = nfree_q;
          used_d = used_q + 1'b1;
        end else begin
          if (prev_q == '0) begin
            head_d = next_q;
          end else begin
            link_we = 1'b1;
            link_wa = prev_q;
            link_wd = next_q;
          end
          if (tail_q == cur_q) begin
            tail_d = prev_q;
          end
          res_slot_d = cur_q;
        end
        state_d = S_COMMIT2;
      end
      S_COMMIT2: begin
        if (op_q == OP_INSERT) begin
          if (prev_q == '0) begin
            head_d = res_slot_q;
          end else begin
            link_we = 1'b1;
            link_wa = prev_q;
            link_wd = res_slot_q;
          end
        end else begin
          link_we = 1'b1;
          link_wa = cur_q;
          link_wd = free_q;
          free_d  = cur_q;
          if (used_q != '0) begin
            used_d = used_q - 1'b1;
          end
        end
        res_status_d = STATUS_DONE;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      free_q      <= IW'(1);
      used_q      <= '0;
      lvld_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      used_q  <= used_d;
      if (link_we) begin
        lvld_q[link_wa] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    v_q          <= v_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    next_q       <= next_d;
    nfree_q      <= nfree_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= SLOT_W'(res_slot_q);
      out_cnt_q    <= CNT_W'(used_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[res_slot_q] <= v_q;
    end
    if (rd_en) begin
      val_rd_q <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (rd_en) begin
      link_rd_q  <= link_mem[rd_addr];
      link_ra_q  <= rd_addr;
      link_hit_q <= lvld_q[rd_addr];
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_o        = out_slot_q;
  assign entry_count_o = out_cnt_q;

endmodule

`default_nettype wire

### hdl/sll_checker.sv
`default_nettype none
`include "assert_macros.svh"

module sll_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input sll_pkg::status_t           status_o,
  input logic [sll_pkg::SLOT_W-1:0] slot_o
);
  import sll_pkg::*;

  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(slot_o), "stalled result word changed")
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
    "engine free right after taking a word")
  `ASSERT_IMPLIES(a_status_code, out_valid_o,
    status_o == STATUS_DONE || status_o == STATUS_FULL || status_o == STATUS_NOTFOUND,
    "status outside the defined codes")
  `ASSERT_IMPLIES(a_fail_slot, out_valid_o && status_o != STATUS_DONE, slot_o == '0,
    "failed operation reports a slot")

endmodule

bind sorted_linked_list_engine_top sll_checker u_sll_checker (.*);

`default_nettype wire
